// File: rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL; each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the cycle where ante holds.
`define GMPS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cond never holds.
`define GMPS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// File: rtl/gmps_pkg.sv
package gmps_pkg;

	// Cell codes
	localparam logic [1:0] KIND_WALL = 2'd1;
	localparam logic [1:0] KIND_SEEN = 2'd2;

	// Register indexes
	localparam logic REG_GRID_ROWS = 1'b0;
	localparam logic REG_GRID_COLS = 1'b1;

	localparam logic [3:0] SIZE_RESET = 4'd8;

	// Direction order N, S, E, W, NW, NE, SW, SE; bit d belongs to direction d
	localparam logic [3:0] DIR_COUNT = 4'd8;
	localparam logic [7:0] DIR_ROW_DEC = 8'b0011_0001;
	localparam logic [7:0] DIR_ROW_INC = 8'b1100_0010;
	localparam logic [7:0] DIR_COL_INC = 8'b1010_0100;
	localparam logic [7:0] DIR_COL_DEC = 8'b0101_1000;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_START,
		ST_START_CHK,
		ST_STEP,
		ST_POP_WAIT,
		ST_CHECK,
		ST_EMIT_EXIT,
		ST_EMIT_TOP,
		ST_EMIT_MEM,
		ST_EMIT_NONE,
		ST_EMIT_SINGLE
	} gmps_state_t;

	typedef struct packed {
		logic load_en;
		logic start_rd;
		logic init_top;
		logic step_dir;
		logic pop;
		logic restore;
		logic push;
		logic emit_exit;
		logic emit_top;
		logic emit_mem;
		logic emit_none;
		logic emit_single;
	} gmps_cmd_t;

	typedef struct packed {
		logic norm_ok;
		logic last_cell;
		logic blocked;
		logic single;
		logic dir_done;
		logic in_bounds;
		logic is_exit;
		logic depth_one;
		logic depth_zero;
		logic ptr_zero;
		logic out_free;
	} gmps_sts_t;

	// Clamp a size register: zero acts as one, above the maximum acts as the maximum
	function automatic logic [3:0] eff_size(input logic [3:0] v, input int maxv);
		logic [3:0] r;
		if (v == 4'd0) begin
			r = 4'd1;
		end else if (int'(v) > maxv) begin
			r = 4'(maxv);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// File: rtl/gmps_ctrl.sv
module gmps_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               cfg_wr_en,
	input  gmps_pkg::gmps_sts_t sts,
	output logic               in_stall,
	output gmps_pkg::gmps_cmd_t cmd
);
	import gmps_pkg::*;

	gmps_state_t state_q;
	gmps_state_t state_d;
	logic        ready;

	// Take cells only while loading, with the column counter in range and no size write
	assign ready    = (state_q == ST_LOAD) && sts.norm_ok && !cfg_wr_en;
	assign in_stall = !ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (ready && in_valid && sts.last_cell) state_d = ST_START;
			end
			ST_START: state_d = ST_START_CHK;
			ST_START_CHK: begin
				if (sts.blocked) state_d = ST_EMIT_NONE;
				else if (sts.single) state_d = ST_EMIT_SINGLE;
				else state_d = ST_STEP;
			end
			ST_STEP: begin
				if (sts.depth_zero) state_d = ST_EMIT_NONE;
				else if (sts.dir_done) state_d = sts.depth_one ? ST_STEP : ST_POP_WAIT;
				else if (sts.in_bounds) state_d = ST_CHECK;
			end
			ST_POP_WAIT: state_d = ST_STEP;
			ST_CHECK: begin
				if (!sts.blocked && sts.is_exit) state_d = ST_EMIT_EXIT;
				else state_d = ST_STEP;
			end
			ST_EMIT_EXIT: begin
				if (sts.out_free) state_d = ST_EMIT_TOP;
			end
			ST_EMIT_TOP: begin
				if (sts.out_free) state_d = sts.depth_one ? ST_LOAD : ST_EMIT_MEM;
			end
			ST_EMIT_MEM: begin
				if (sts.out_free && sts.ptr_zero) state_d = ST_LOAD;
			end
			ST_EMIT_NONE, ST_EMIT_SINGLE: begin
				if (sts.out_free) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_LOAD: cmd.load_en = ready && in_valid;
			ST_START: cmd.start_rd = 1'b1;
			ST_START_CHK: cmd.init_top = !sts.blocked && !sts.single;
			ST_STEP: begin
				if (!sts.depth_zero) begin
					cmd.pop      = sts.dir_done;
					cmd.step_dir = !sts.dir_done;
				end
			end
			ST_POP_WAIT: cmd.restore = 1'b1;
			ST_CHECK: cmd.push = !sts.blocked && !sts.is_exit;
			ST_EMIT_EXIT: cmd.emit_exit = sts.out_free;
			ST_EMIT_TOP: cmd.emit_top = sts.out_free;
			ST_EMIT_MEM: cmd.emit_mem = sts.out_free;
			ST_EMIT_NONE: cmd.emit_none = sts.out_free;
			ST_EMIT_SINGLE: cmd.emit_single = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// File: rtl/gmps_dpath.sv
module gmps_dpath #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gmps_pkg::gmps_cmd_t cmd,
	output gmps_pkg::gmps_sts_t sts,
	input  logic [1:0]         cell_kind,
	input  logic               cfg_wr_en,
	input  logic               cfg_index,
	input  logic [3:0]         cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         path_row,
	output logic [3:0]         path_col,
	output logic               found,
	output logic               last
);
	import gmps_pkg::*;

	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int AW    = RW + CW;
	localparam int DEPTH = 1 << AW;
	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int LCW   = $clog2(CELLS + 1);
	localparam int DW    = AW + 1;
	localparam int STK_W = RW + CW + 4;
	localparam int XW0   = (LCW > RW) ? LCW : RW;
	localparam int XW1   = (XW0 > CW) ? XW0 : CW;
	localparam int XW    = ((XW1 > 8) ? XW1 : 8) + 1;

	// Size registers and derived sizes
	logic [3:0] grid_rows_q;
	logic [3:0] grid_cols_q;
	logic [3:0] rows_eff;
	logic [3:0] cols_eff;
	logic [7:0] total;

	// Load position
	logic [LCW-1:0] load_count_q;
	logic [LCW-1:0] lr_q;
	logic [LCW-1:0] lc_q;
	logic           row_in;

	// Search state
	logic [RW-1:0] cur_r_q;
	logic [CW-1:0] cur_c_q;
	logic [3:0]    cur_d_q;
	logic [RW-1:0] nbr_r_q;
	logic [CW-1:0] nbr_c_q;
	logic [DW-1:0] depth_q;
	logic [DW-1:0] depth_m2;
	logic [AW-1:0] ptr_q;

	// Neighbor logic
	logic [2:0]    dsel;
	logic          up;
	logic          down;
	logic          right;
	logic          left;
	logic          r_out;
	logic          c_out;
	logic [RW-1:0] nr_next;
	logic [CW-1:0] nc_next;

	// Stores
	logic [1:0]       cell_mem [DEPTH];
	logic [STK_W-1:0] stk_mem  [DEPTH];
	logic             cell_we;
	logic [AW-1:0]    cell_wa;
	logic [1:0]       cell_wd;
	logic [AW-1:0]    cell_ra;
	logic [1:0]       cell_rd_q;
	logic [AW-1:0]    stk_ra;
	logic [STK_W-1:0] stk_rd_q;
	logic [RW-1:0]    stk_r;
	logic [CW-1:0]    stk_c;
	logic [3:0]       stk_d;

	logic out_valid_q;
	logic emit_any;

	assign rows_eff = eff_size(grid_rows_q, MAX_ROWS);
	assign cols_eff = eff_size(grid_cols_q, MAX_COLS);
	assign total    = 8'(rows_eff) * 8'(cols_eff);
	assign row_in   = XW'(lr_q) < XW'(rows_eff);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= SIZE_RESET;
			grid_cols_q <= SIZE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_GRID_ROWS: grid_rows_q <= cfg_data;
				REG_GRID_COLS: grid_cols_q <= cfg_data;
				default: grid_rows_q <= grid_rows_q;
			endcase
		end
	end

	// Load counter with row and column; a size write re-derives them by subtraction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
			lr_q         <= '0;
			lc_q         <= '0;
		end else if (cfg_wr_en) begin
			lc_q <= load_count_q;
			lr_q <= '0;
		end else if (cmd.load_en) begin
			if (sts.last_cell) begin
				load_count_q <= '0;
				lr_q         <= '0;
				lc_q         <= '0;
			end else begin
				load_count_q <= load_count_q + 1'b1;
				if (XW'(lc_q) + XW'(1) == XW'(cols_eff)) begin
					lc_q <= '0;
					lr_q <= lr_q + 1'b1;
				end else begin
					lc_q <= lc_q + 1'b1;
				end
			end
		end else if (!sts.norm_ok) begin
			lc_q <= LCW'(XW'(lc_q) - XW'(cols_eff));
			lr_q <= lr_q + 1'b1;
		end
	end

	// Neighbor of the top entry in its current direction
	assign dsel    = cur_d_q[2:0];
	assign up      = DIR_ROW_DEC[dsel];
	assign down    = DIR_ROW_INC[dsel];
	assign right   = DIR_COL_INC[dsel];
	assign left    = DIR_COL_DEC[dsel];
	assign r_out   = (up && (cur_r_q == '0)) ||
	                 (down && (XW'(cur_r_q) + XW'(1) >= XW'(rows_eff)));
	assign c_out   = (left && (cur_c_q == '0)) ||
	                 (right && (XW'(cur_c_q) + XW'(1) >= XW'(cols_eff)));
	assign nr_next = up ? cur_r_q - 1'b1 : (down ? cur_r_q + 1'b1 : cur_r_q);
	assign nc_next = left ? cur_c_q - 1'b1 : (right ? cur_c_q + 1'b1 : cur_c_q);

	assign depth_m2 = depth_q - DW'(2);

	// Search registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			ptr_q   <= '0;
			cur_r_q <= '0;
			cur_c_q <= '0;
			cur_d_q <= '0;
			nbr_r_q <= '0;
			nbr_c_q <= '0;
		end else begin
			if (cmd.init_top) begin
				cur_r_q <= '0;
				cur_c_q <= '0;
				cur_d_q <= '0;
				depth_q <= DW'(1);
			end
			if (cmd.step_dir) begin
				cur_d_q <= cur_d_q + 1'b1;
				nbr_r_q <= nr_next;
				nbr_c_q <= nc_next;
			end
			if (cmd.pop) depth_q <= depth_q - 1'b1;
			if (cmd.restore) begin
				cur_r_q <= stk_r;
				cur_c_q <= stk_c;
				cur_d_q <= stk_d;
			end
			if (cmd.push) begin
				cur_r_q <= nbr_r_q;
				cur_c_q <= nbr_c_q;
				cur_d_q <= '0;
				depth_q <= depth_q + 1'b1;
			end
			if (cmd.emit_top) ptr_q <= depth_m2[AW-1:0];
			if (cmd.emit_mem) ptr_q <= ptr_q - 1'b1;
		end
	end

	// Cell store: load writes, visit marks, one registered read
	always_comb begin
		cell_we = 1'b0;
		cell_wa = {nbr_r_q, nbr_c_q};
		cell_wd = KIND_SEEN;
		priority if (cmd.load_en) begin
			cell_we = row_in;
			cell_wa = {lr_q[RW-1:0], lc_q[CW-1:0]};
			cell_wd = cell_kind;
		end else if (cmd.init_top) begin
			cell_we = 1'b1;
			cell_wa = '0;
		end else if (cmd.push) begin
			cell_we = 1'b1;
		end
	end

	assign cell_ra = cmd.start_rd ? '0 : {nr_next, nc_next};

	always_ff @(posedge clk) begin
		if (cell_we) cell_mem[cell_wa] <= cell_wd;
		if (cmd.start_rd || cmd.step_dir) cell_rd_q <= cell_mem[cell_ra];
	end

	// Walk stack: entries below the top, top kept in registers
	assign stk_ra = cmd.emit_mem ? ptr_q - 1'b1 : depth_m2[AW-1:0];
	assign {stk_r, stk_c, stk_d} = stk_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.push) stk_mem[depth_m2[AW-1:0] + 1'b1] <= {cur_r_q, cur_c_q, cur_d_q};
		if (cmd.pop || cmd.emit_top || cmd.emit_mem) stk_rd_q <= stk_mem[stk_ra];
	end

	// Result register
	assign emit_any = cmd.emit_exit || cmd.emit_top || cmd.emit_mem ||
	                  cmd.emit_none || cmd.emit_single;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_any) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.emit_exit) begin
			path_row <= rows_eff;
			path_col <= cols_eff;
			found    <= 1'b1;
			last     <= 1'b0;
		end else if (cmd.emit_top) begin
			path_row <= 4'(XW'(cur_r_q) + XW'(1));
			path_col <= 4'(XW'(cur_c_q) + XW'(1));
			found    <= 1'b1;
			last     <= sts.depth_one;
		end else if (cmd.emit_mem) begin
			path_row <= 4'(XW'(stk_r) + XW'(1));
			path_col <= 4'(XW'(stk_c) + XW'(1));
			found    <= 1'b1;
			last     <= sts.ptr_zero;
		end else if (cmd.emit_none) begin
			path_row <= 4'd0;
			path_col <= 4'd0;
			found    <= 1'b0;
			last     <= 1'b1;
		end else if (cmd.emit_single) begin
			path_row <= 4'd1;
			path_col <= 4'd1;
			found    <= 1'b1;
			last     <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

	// Status to the controller
	always_comb begin
		sts.norm_ok    = XW'(lc_q) < XW'(cols_eff);
		sts.last_cell  = (XW'(load_count_q) + XW'(1)) >= XW'(total);
		sts.blocked    = (cell_rd_q == KIND_WALL) || (cell_rd_q == KIND_SEEN);
		sts.single     = (rows_eff == 4'd1) && (cols_eff == 4'd1);
		sts.dir_done   = cur_d_q == DIR_COUNT;
		sts.in_bounds  = !r_out && !c_out;
		sts.is_exit    = (XW'(nbr_r_q) + XW'(1) == XW'(rows_eff)) &&
		                 (XW'(nbr_c_q) + XW'(1) == XW'(cols_eff));
		sts.depth_one  = depth_q == DW'(1);
		sts.depth_zero = depth_q == '0;
		sts.ptr_zero   = ptr_q == '0;
		sts.out_free   = !out_valid_q || !out_stall;
	end

endmodule

// File: rtl/grid_maze_path_search_unit.sv
// Maze path search over a grid of up to MAX_ROWS x MAX_COLS cells. Cells stream in on the
// input channel in row-major order, one per cycle while the input is not stalled, for the
// size set in grid_rows and grid_cols. A size write during a load stalls the input while
// the row and column counters are rebuilt by subtraction. After the last cell the block
// stalls its input and runs a depth-first search from the top-left to the bottom-right
// cell, trying N, S, E, W, NW, NE, SW, SE. A direction whose neighbor lies on the grid also
// reads the cell store through its registered read; a backtrack reads the walk stack, also
// registered. Results then leave at one per cycle while the output is not stalled: the exit,
// then the path back to the start with last on the start cell, or a single result with found
// low when no path exists or high on a one-cell grid. Loading resumes once the last result
// has been placed in the output register, even while it still waits there.
`include "assert_macros.svh"

module grid_maze_path_search_unit #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cell_kind,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] path_row,
	output logic [3:0] path_col,
	output logic       found,
	output logic       last,
	input  logic       cfg_wr_en,
	input  logic       cfg_index,
	input  logic [3:0] cfg_data
);
	import gmps_pkg::*;

	gmps_cmd_t cmd;
	gmps_sts_t sts;
	logic      emit_any;

	gmps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cfg_wr_en (cfg_wr_en),
		.sts       (sts),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	gmps_dpath #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cell_kind (cell_kind),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.path_row  (path_row),
		.path_col  (path_col),
		.found     (found),
		.last      (last)
	);

	assign emit_any = cmd.emit_exit || cmd.emit_top || cmd.emit_mem ||
	                  cmd.emit_none || cmd.emit_single;

	`GMPS_ASSERT_NEVER(a_no_overwrite, emit_any && out_valid && out_stall, "result overwritten")
	`GMPS_ASSERT_IMP(a_miss_is_last, out_valid && !found, last && path_row == 4'd0, "bad miss")
	`GMPS_ASSERT_IMP(a_path_coords, out_valid && found, path_row != 4'd0 && path_col != 4'd0,
		"path coordinate zero")

endmodule
